@@ src/psrd_pkg.sv @@
// Shared types and protocol constants for the packet stream receive deframer.
package psrd_pkg;

    // One input request: a mode code and the byte that came from the host.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } psrd_in_t;

    // One result request: a payload byte or a reply byte, with end status.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       last;
    } psrd_out_t;

    // Input modes.
    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_START   = 2'd2;

    // Transfer phases.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_HDR_BAD = 3'd2;
    localparam logic [2:0] PH_BETWEEN = 3'd3;
    localparam logic [2:0] PH_LEN_HI  = 3'd4;
    localparam logic [2:0] PH_LEN_LO  = 3'd5;
    localparam logic [2:0] PH_DATA    = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    // Protocol bytes.
    localparam logic [7:0] B_BEGIN  = 8'h07;
    localparam logic [7:0] B_HEAD   = 8'h14;
    localparam logic [7:0] B_PACKET = 8'h15;
    localparam logic [7:0] B_END    = 8'h16;
    localparam logic [7:0] B_ACK    = 8'h17;
    localparam logic [7:0] B_NAK    = 8'h18;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    // End-of-transfer status codes.
    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_DONE_OK  = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_BAD_HEAD = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    // Register indexes on the configuration port.
    localparam logic REG_CHECK_COUNT    = 1'b0;
    localparam logic REG_EXPECTED_COUNT = 1'b1;

    // Index of the last header byte (marker plus four total bytes).
    localparam logic [2:0] HEADER_LAST = 3'd4;

endpackage

@@ src/packet_stream_receive_deframer_unit.sv @@
// Top level of the packet stream receive deframer: phase logic and result queue.
//
//  Channel   Ports                     Direction  Moves
//  s_        s_valid s_ready s_data    in         mode and received byte
//  m_        m_valid m_ready m_data    out        payload or reply byte, status, last
//  APB       psel penable pwrite ...   in/out     check_count, expected_count
//
// Each input request, when taken, writes its zero, one or two results into a
// four-entry result queue at that same edge; the queue drains one result a cycle
// while m_ready is high. s_ready is high while the queue has room for two results,
// so with a ready consumer the block takes one request every cycle.
// aresetn is synchronous and active low; it clears phase, counters and the queue.
// A stalled m_ready holds the queue head; input stops once more than two results wait.
module packet_stream_receive_deframer_unit
    import psrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  psrd_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output psrd_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QDepth = 4;
    localparam int PtrW   = $clog2(QDepth);

    // Configuration registers.
    logic        check_count_reg;
    logic [31:0] expected_count_reg;

    // Transfer state.
    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [31:0] announced_total_reg, announced_total_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] packet_left_reg, packet_left_next;
    logic [31:0] received_total_reg, received_total_next;

    // Results produced by the current request.
    psrd_out_t   res0, res1;
    logic [1:0]  res_count;

    // Result queue.
    psrd_out_t   queue_reg [QDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   count_reg;

    logic in_fire, out_fire, cfg_write;
    logic [15:0] packet_dec;
    logic [15:0] length_full;

    assign in_fire   = s_valid & s_ready;
    assign out_fire  = m_valid & m_ready;
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    // Configuration write and read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_count_reg    <= 1'b0;
            expected_count_reg <= 32'd0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_CHECK_COUNT:    check_count_reg    <= pwdata[0];
                REG_EXPECTED_COUNT: expected_count_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CHECK_COUNT:    prdata = {31'd0, check_count_reg};
            REG_EXPECTED_COUNT: prdata = expected_count_reg;
            default:            prdata = 32'd0;
        endcase
    end

    assign packet_dec  = packet_left_reg - 16'd1;
    assign length_full = {length_high_reg, s_data.rx_byte};

    // Phase logic for one request.
    always_comb begin
        phase_next           = phase_reg;
        header_index_next    = header_index_reg;
        announced_total_next = announced_total_reg;
        length_high_next     = length_high_reg;
        packet_left_next     = packet_left_reg;
        received_total_next  = received_total_reg;
        res0      = '{kind: KIND_REPLY, data_byte: B_ACK, status: ST_RUNNING, last: 1'b1};
        res1      = '{kind: KIND_REPLY, data_byte: B_ACK, status: ST_RUNNING, last: 1'b1};
        res_count = 2'd0;

        case (s_data.mode)
            MODE_START: begin
                phase_next           = PH_HEADER;
                header_index_next    = 3'd0;
                announced_total_next = 32'd0;
                length_high_next     = 8'd0;
                packet_left_next     = 16'd0;
                received_total_next  = 32'd0;
                res0.data_byte       = B_BEGIN;
                res_count            = 2'd1;
            end
            MODE_TIMEOUT: begin
                if (phase_reg == PH_HEADER || phase_reg == PH_HDR_BAD ||
                    phase_reg == PH_DATA) begin
                    phase_next     = PH_DONE;
                    res0.data_byte = B_NAK;
                    res0.status    = ST_TIMEOUT;
                    res_count      = 2'd1;
                end else if (phase_reg == PH_BETWEEN || phase_reg == PH_LEN_HI ||
                             phase_reg == PH_LEN_LO) begin
                    phase_next = PH_DONE;
                end
            end
            MODE_BYTE: begin
                case (phase_reg)
                    PH_HEADER, PH_HDR_BAD: begin
                        if (header_index_reg == 3'd0) begin
                            if (s_data.rx_byte != B_HEAD) begin
                                phase_next = PH_HDR_BAD;
                            end
                        end else begin
                            announced_total_next = {announced_total_reg[23:0],
                                                    s_data.rx_byte};
                        end
                        header_index_next = header_index_reg + 3'd1;
                        // Last header byte: verdict on the marker.
                        if (header_index_reg == HEADER_LAST) begin
                            header_index_next = 3'd0;
                            res_count         = 2'd1;
                            if (phase_reg == PH_HDR_BAD ||
                                (header_index_reg == 3'd0 && s_data.rx_byte != B_HEAD)) begin
                                phase_next     = PH_DONE;
                                res0.data_byte = B_NAK;
                                res0.status    = ST_BAD_HEAD;
                            end else begin
                                phase_next = PH_BETWEEN;
                            end
                        end
                    end
                    PH_BETWEEN: begin
                        if (s_data.rx_byte == B_END) begin
                            phase_next = PH_DONE;
                            res_count  = 2'd1;
                            if (check_count_reg &&
                                expected_count_reg != received_total_reg) begin
                                res0.data_byte = B_NAK;
                                res0.status    = ST_MISMATCH;
                            end else begin
                                res0.status = ST_DONE_OK;
                            end
                        end else if (s_data.rx_byte == B_PACKET) begin
                            phase_next = PH_LEN_HI;
                        end else begin
                            // A stray byte is acknowledged and ignored.
                            res_count = 2'd1;
                        end
                    end
                    PH_LEN_HI: begin
                        length_high_next = s_data.rx_byte;
                        phase_next       = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        packet_left_next = length_full;
                        if (length_full == 16'd0) begin
                            phase_next = PH_BETWEEN;
                            res_count  = 2'd1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        received_total_next = received_total_reg + 32'd1;
                        packet_left_next    = packet_dec;
                        res0.kind           = KIND_PAYLOAD;
                        res0.data_byte      = s_data.rx_byte;
                        if (packet_dec == 16'd0) begin
                            // The last payload byte is followed by the packet ACK.
                            phase_next = PH_BETWEEN;
                            res0.last  = 1'b0;
                            res_count  = 2'd2;
                        end else begin
                            res_count = 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Transfer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            header_index_reg    <= 3'd0;
            announced_total_reg <= 32'd0;
            length_high_reg     <= 8'd0;
            packet_left_reg     <= 16'd0;
            received_total_reg  <= 32'd0;
        end else if (in_fire) begin
            phase_reg           <= phase_next;
            header_index_reg    <= header_index_next;
            announced_total_reg <= announced_total_next;
            length_high_reg     <= length_high_next;
            packet_left_reg     <= packet_left_next;
            received_total_reg  <= received_total_next;
        end
    end

    // Result queue storage; a request writes none, one or two consecutive entries.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (res_count != 2'd0) begin
                queue_reg[wr_ptr_reg] <= res0;
            end
            if (res_count == 2'd2) begin
                queue_reg[wr_ptr_reg + PtrW'(1)] <= res1;
            end
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_fire) begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(res_count);
            end
            if (out_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_reg + (in_fire ? (PtrW+1)'(res_count) : '0)
                         - (PtrW+1)'(out_fire);
        end
    end

    assign s_ready = (count_reg <= (PtrW+1)'(QDepth - 2));
    assign m_valid = (count_reg != '0);
    assign m_data  = queue_reg[rd_ptr_reg];

endmodule
